// ----- design/mted_pkg.sv -----
// Shared types and constants for the Manchester edge timing decoder.
`timescale 1ns / 1ps
`default_nettype none

package mted_pkg;

    localparam int STAMP_W     = 32;
    localparam int IDX_W       = 10;
    localparam int HEADER_BITS = 2;

    typedef enum logic [1:0] {
        KIND_DATA = 2'd0,
        KIND_END  = 2'd1,
        KIND_LOST = 2'd2
    } result_kind_t;

    typedef struct packed {
        logic               level;
        logic [STAMP_W-1:0] stamp;
    } edge_item_t;

    typedef struct packed {
        result_kind_t     kind;
        logic             bit_value;
        logic [IDX_W-1:0] bit_index;
    } result_t;

endpackage

`default_nettype wire

// ----- design/mted_in_reg.sv -----
// Input register that holds one edge transaction for the timing judge.
`timescale 1ns / 1ps
`default_nettype none

module mted_in_reg
    import mted_pkg::*;
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire edge_item_t in_item,
    input  wire logic       fire,
    output logic            item_valid,
    output edge_item_t      item
);

    logic       valid_reg;
    logic       valid_next;
    edge_item_t item_reg;
    logic       take;

    // Stall only while a held transaction cannot move on this cycle
    assign in_stall = valid_reg && !fire;
    assign take     = in_valid && !in_stall;

    always_comb
    begin
        valid_next = valid_reg;
        if (take)
        begin
            valid_next = 1'b1;
        end
        else if (fire)
        begin
            valid_next = 1'b0;
        end
    end

    // Hold control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // Capture payload on accept
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg <= in_item;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

`default_nettype wire

// ----- design/mted_judge.sv -----
// Timing judge: learns header periods, classifies each edge, updates decoder state.
`timescale 1ns / 1ps
`default_nettype none

module mted_judge
    import mted_pkg::*;
#(
    parameter int MAX_BITS = 1024
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       fire,
    input  wire edge_item_t item,
    output logic            res_valid,
    output result_t         res
);

    localparam int CNT_W = $clog2(MAX_BITS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_BITS);
    localparam logic [CNT_W-1:0] HDR_CNT = CNT_W'(HEADER_BITS);

    logic [STAMP_W-1:0] last_reg, last_next;
    logic [STAMP_W-1:0] low_reg, low_next;
    logic [STAMP_W-1:0] high_reg, high_next;
    logic               started_reg, started_next;
    logic               await_high_reg, await_high_next;
    logic               learned_reg, learned_next;
    logic [CNT_W-1:0]   count_reg, count_next;

    logic               learn_low;
    logic               learn_high;
    logic               start;
    logic [STAMP_W-1:0] gap_raw;
    logic [STAMP_W-1:0] last_eff;
    logic [STAMP_W-1:0] low_eff;
    logic [STAMP_W-1:0] high_eff;
    logic               learned_eff;
    logic               started_eff;
    logic [STAMP_W-1:0] period;
    logic [STAMP_W-1:0] gap;
    logic [STAMP_W-1:0] err;
    logic [STAMP_W+1:0] period_x3;
    logic               is_end;
    logic               is_far;
    logic               judged;
    logic               accept;
    logic               room;
    logic [CNT_W-1:0]   pos_hdr;
    logic [CNT_W+IDX_W-1:0] idx_wide;

    // Header learning and timing start
    assign learn_low  = (low_reg == '0) && started_reg && !item.level;
    assign learn_high = await_high_reg && item.level && started_reg;
    assign start      = !started_reg && !item.level;
    assign gap_raw    = item.stamp - last_reg;

    assign last_eff    = start ? item.stamp : last_reg;
    assign low_eff     = learn_low ? gap_raw : low_reg;
    assign high_eff    = learn_high ? gap_raw : high_reg;
    assign learned_eff = learned_reg || learn_low || learn_high;
    assign started_eff = started_reg || start;

    // Measure the edge against the period for its direction
    assign period    = item.level ? high_eff : low_eff;
    assign gap       = item.stamp - last_eff;
    assign err       = (period >= gap) ? (period - gap) : (gap - period);
    assign period_x3 = {1'b0, period, 1'b0} + {2'b00, period};
    assign is_end    = {2'b00, err} > period_x3;
    assign is_far    = {err, 2'b00} > {2'b00, period};

    assign judged = started_eff && (period != '0) && learned_eff;
    assign accept = judged && !is_end && !is_far;
    assign room   = count_reg < MAX_CNT;

    // Data bit position, header excluded, wrapped to the index width
    assign pos_hdr  = count_reg - HDR_CNT;
    assign idx_wide = {{IDX_W{1'b0}}, pos_hdr};

    always_comb
    begin
        res_valid     = 1'b0;
        res.kind      = KIND_DATA;
        res.bit_value = 1'b0;
        res.bit_index = '0;
        if (judged && is_end)
        begin
            res_valid = 1'b1;
            res.kind  = KIND_END;
        end
        else if (accept)
        begin
            if (!room)
            begin
                res_valid = 1'b1;
                res.kind  = KIND_LOST;
            end
            else if (count_reg >= HDR_CNT)
            begin
                res_valid     = 1'b1;
                res.kind      = KIND_DATA;
                res.bit_value = !item.level;
                res.bit_index = idx_wide[IDX_W-1:0];
            end
        end
    end

    // Next state
    always_comb
    begin
        last_next       = last_reg;
        low_next        = low_reg;
        high_next       = high_reg;
        started_next    = started_reg;
        await_high_next = await_high_reg;
        learned_next    = learned_reg;
        count_next      = count_reg;
        if (fire)
        begin
            last_next    = accept ? item.stamp : last_eff;
            low_next     = low_eff;
            high_next    = high_eff;
            started_next = started_eff;
            learned_next = learned_eff;
            if (learn_high)
            begin
                await_high_next = 1'b0;
            end
            if (accept && room)
            begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    // Advance state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_reg       <= '0;
            low_reg        <= '0;
            high_reg       <= '0;
            started_reg    <= 1'b0;
            await_high_reg <= 1'b1;
            learned_reg    <= 1'b0;
            count_reg      <= '0;
        end
        else
        begin
            last_reg       <= last_next;
            low_reg        <= low_next;
            high_reg       <= high_next;
            started_reg    <= started_next;
            await_high_reg <= await_high_next;
            learned_reg    <= learned_next;
            count_reg      <= count_next;
        end
    end

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_CNT)
        else $error("accepted edge count passed capacity");

    a_started_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        started_reg |=> started_reg)
        else $error("timing start flag dropped");

    a_high_learned: assert property (@(posedge clk) disable iff (!rst_n)
        !await_high_reg |-> (learned_reg && started_reg))
        else $error("high period learned without start");

    a_accept_moves_last: assert property (@(posedge clk) disable iff (!rst_n)
        (fire && accept) |=> (last_reg == $past(item.stamp)))
        else $error("accepted edge did not move reference time");

endmodule

`default_nettype wire

// ----- design/mted_out_reg.sv -----
// Result register that holds one decoded transaction until the sink takes it.
`timescale 1ns / 1ps
`default_nettype none

module mted_out_reg
    import mted_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    load,
    input  wire result_t res,
    input  wire logic    out_stall,
    output logic         out_valid,
    output result_t      out_res
);

    logic    valid_reg;
    logic    valid_next;
    result_t res_reg;

    // Load a new result, or drop the held one once taken
    always_comb
    begin
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= res;
        end
    end

    assign out_valid = valid_reg;
    assign out_res   = res_reg;

endmodule

`default_nettype wire

// ----- design/manchester_edge_timing_decoder_top.sv -----
// Top level of the Manchester edge timing decoder.
//
//  Channel | Handshake            | Payload
//  --------+----------------------+-----------------------------------------
//  input   | in_valid / in_stall  | edge_level, edge_time
//  output  | out_valid / out_stall| result_kind, bit_value, bit_index
//
// One edge transaction per cycle while the result channel is not stalled; each
// edge passes the input register, then the judge into the result register.
// The state loop through the period compare sets the rate.
// Reset clears all timing state; periods return to unlearned.
// A stalled result holds the pipe after one more transaction is buffered.
`timescale 1ns / 1ps
`default_nettype none

module manchester_edge_timing_decoder_top
    import mted_pkg::*;
#(
    parameter int MAX_BITS = 1024
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_stall,
    input  wire logic               edge_level,
    input  wire logic [STAMP_W-1:0] edge_time,
    output logic                    out_valid,
    input  wire logic               out_stall,
    output logic [1:0]              result_kind,
    output logic                    bit_value,
    output logic [IDX_W-1:0]        bit_index
);

    edge_item_t in_item;
    edge_item_t item;
    logic       item_valid;
    logic       fire;
    logic       res_valid;
    result_t    res;
    result_t    out_res;

    assign in_item.level = edge_level;
    assign in_item.stamp = edge_time;

    // Advance the held transaction when the result register can take it
    assign fire = item_valid && (!out_valid || !out_stall);

    mted_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .in_item    (in_item),
        .fire       (fire),
        .item_valid (item_valid),
        .item       (item)
    );

    mted_judge #(
        .MAX_BITS (MAX_BITS)
    ) u_judge (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    mted_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (fire && res_valid),
        .res       (res),
        .out_stall (out_stall),
        .out_valid (out_valid),
        .out_res   (out_res)
    );

    assign result_kind = out_res.kind;
    assign bit_value   = out_res.bit_value;
    assign bit_index   = out_res.bit_index;

endmodule

`default_nettype wire

// ----- sim/testbench.sv -----
// Testbench for the edge timing decoder: directed edges, then random edges against a predictor.
`timescale 1ns / 1ps

module testbench;
    import mted_pkg::*;

    localparam int          CAPACITY     = 1024;
    localparam int unsigned LOW_PERIOD   = 1000;
    localparam int unsigned HIGH_PERIOD  = 800;
    localparam int          RANDOM_EDGES = 500;
    localparam int          SETTLE_CYCLES = 8;
    localparam int          CYCLE_LIMIT  = 200000;

    typedef enum {
        ROW_PREDICTED,
        ROW_SILENT,
        ROW_GIVEN
    } row_check_t;

    typedef struct {
        logic               level;
        logic [STAMP_W-1:0] stamp;
        row_check_t         check;
        result_t            want;
    } edge_row_t;

    localparam result_t NO_BIT   = '{KIND_DATA, 1'b0, 10'd0};
    localparam result_t END_SEEN = '{KIND_END, 1'b0, 10'd0};

    // Learn high 800 and low 1000 from a header that starts just before the wrap.
    edge_row_t edge_table [16] = '{
        // high edges before the first low edge are not timed
        '{1'b1, 32'hFFFF_FFFF, ROW_SILENT, NO_BIT},
        '{1'b1, 32'h0000_0000, ROW_SILENT, NO_BIT},
        // first low edge starts the timing
        '{1'b0, 32'hFFFF_FC00, ROW_SILENT, NO_BIT},
        // zero interval leaves the low period at zero, so the edge is not judged
        '{1'b0, 32'hFFFF_FC00, ROW_SILENT, NO_BIT},
        // header: high period learned, then low period relearned across the wrap
        '{1'b1, 32'hFFFF_FF20, ROW_SILENT, NO_BIT},
        '{1'b0, 32'h0000_0308, ROW_SILENT, NO_BIT},
        '{1'b1, 32'h0000_0628, ROW_GIVEN, '{KIND_DATA, 1'b0, 10'd0}},
        // exactly 25 percent late is still accepted
        '{1'b0, 32'h0000_0B0A, ROW_PREDICTED, NO_BIT},
        // just over 25 percent late is ignored
        '{1'b1, 32'h0000_0EF3, ROW_PREDICTED, NO_BIT},
        // exactly 25 percent early is accepted
        '{1'b1, 32'h0000_0D62, ROW_PREDICTED, NO_BIT},
        // exactly 300 percent off is ignored, one more is end of message
        '{1'b0, 32'h0000_1D02, ROW_PREDICTED, NO_BIT},
        '{1'b0, 32'h0000_1D03, ROW_GIVEN, END_SEEN},
        '{1'b1, 32'h0000_1082, ROW_PREDICTED, NO_BIT},
        // interval wraps to all ones
        '{1'b0, 32'h0000_1081, ROW_GIVEN, END_SEEN},
        '{1'b0, 32'h0000_1082, ROW_PREDICTED, NO_BIT},
        '{1'b0, 32'h0000_146A, ROW_PREDICTED, NO_BIT}
    };

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_stall;
    logic               edge_level = 1'b0;
    logic [STAMP_W-1:0] edge_time = '0;
    logic               out_valid;
    logic               out_stall = 1'b0;
    logic [1:0]         result_kind;
    logic               bit_value;
    logic [IDX_W-1:0]   bit_index;

    int unsigned idle_pct = 0;
    int unsigned stall_pct = 0;
    int unsigned mismatches = 0;
    int unsigned cycle_count = 0;
    result_t     pending_bits [$];

    // Decoder state mirrored by the predictor
    logic [STAMP_W-1:0] prev_accept = '0;
    logic               started = 1'b0;
    logic [STAMP_W-1:0] low_period = '0;
    logic [STAMP_W-1:0] high_period = '0;
    logic               wait_low = 1'b1;
    logic               wait_high = 1'b1;
    logic               learned = 1'b0;
    int unsigned        accepted = 0;

    manchester_edge_timing_decoder_top #(
        .MAX_BITS(CAPACITY)
    ) i_dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .edge_level(edge_level),
        .edge_time(edge_time),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .result_kind(result_kind),
        .bit_value(bit_value),
        .bit_index(bit_index)
    );

    always #2 clk = ~clk;

    // Judge one edge and advance the mirrored state; return 1 when it yields a result
    function automatic bit decode_edge(input logic lvl, input logic [STAMP_W-1:0] stamp,
                                       output result_t res);
        logic [STAMP_W-1:0] per;
        logic [STAMP_W-1:0] gap;
        longint unsigned    span;
        longint unsigned    miss;
        int unsigned        slot;
        res = NO_BIT;
        if (low_period == '0 && !wait_low && !lvl)
        begin
            low_period = stamp - prev_accept;
            learned = 1'b1;
        end
        if (wait_high && lvl && !wait_low)
        begin
            high_period = stamp - prev_accept;
            wait_high = 1'b0;
            learned = 1'b1;
        end
        if (wait_low && !lvl)
        begin
            prev_accept = stamp;
            wait_low = 1'b0;
            started = 1'b1;
        end
        per = lvl ? high_period : low_period;
        gap = stamp - prev_accept;
        span = per;
        miss = (per >= gap) ? longint'(per - gap) : longint'(gap - per);
        if (!started || per == '0 || !learned)
            return 1'b0;
        if (miss > 3 * span)
        begin
            res.kind = KIND_END;
            return 1'b1;
        end
        if (4 * miss > span)
            return 1'b0;
        prev_accept = stamp;
        if (accepted < CAPACITY)
        begin
            slot = accepted;
            accepted++;
            if (slot < HEADER_BITS)
                return 1'b0;
            res.kind = KIND_DATA;
            res.bit_value = ~lvl;
            res.bit_index = IDX_W'(slot - HEADER_BITS);
            return 1'b1;
        end
        res.kind = KIND_LOST;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatches < 100)
            $display("mismatch at %0t ns: %s", $time, what);
        mismatches++;
    endtask

    // Offer one edge transaction, hold it until accepted, then queue its expected bit
    task automatic send_edge(input logic lvl, input logic [STAMP_W-1:0] stamp,
                             input row_check_t check, input result_t want);
        result_t res;
        bit      yields;
        while ($urandom_range(0, 99) < idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid   <= 1'b1;
        edge_level <= lvl;
        edge_time  <= stamp;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        yields = decode_edge(lvl, stamp, res);
        case (check)
            ROW_PREDICTED: if (yields) pending_bits.push_back(res);
            ROW_GIVEN:     pending_bits.push_back(want);
            default:       ;
        endcase
    endtask

    // Build one random edge: mostly on time, some on the window limits, mid-bit, late or noise
    task automatic random_edge();
        logic               lvl;
        logic [STAMP_W-1:0] per;
        logic [STAMP_W-1:0] q;
        logic [STAMP_W-1:0] gap;
        logic [STAMP_W-1:0] stamp;
        int unsigned        pick;
        lvl = 1'($urandom_range(0, 1));
        per = lvl ? HIGH_PERIOD : LOW_PERIOD;
        q = per / 4;
        pick = $urandom_range(0, 99);
        if (pick < 70)
            gap = per - q + $urandom_range(0, 2 * q);
        else if (pick < 80)
        begin
            case ($urandom_range(0, 7))
                0:       gap = per - q - 1;
                1:       gap = per - q;
                2:       gap = per + q;
                3:       gap = per + q + 1;
                4:       gap = 4 * per;
                5:       gap = 4 * per + 1;
                6:       gap = '0;
                default: gap = '1;
            endcase
        end
        else if (pick < 88)
            gap = per / 2 - per / 8 + $urandom_range(0, per / 4);
        else
            gap = 4 * per + 1 + $urandom_range(0, 1000000);
        stamp = prev_accept + gap;
        if (pick >= 94)
            stamp = $urandom;
        send_edge(lvl, stamp, ROW_PREDICTED, NO_BIT);
    endtask

    // Stall the result channel at random
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Compare each result transaction with the oldest expected bit
    always @(posedge clk)
    begin : check_results
        result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_bits.size() == 0)
                report_mismatch($sformatf("unexpected result kind %0d value %0d index %0d",
                                          result_kind, bit_value, bit_index));
            else
            begin
                want = pending_bits.pop_front();
                if (result_kind !== want.kind)
                    report_mismatch($sformatf("kind %0d, expected %s",
                                              result_kind, want.kind.name()));
                if (bit_value !== want.bit_value)
                    report_mismatch($sformatf("bit value %0d, expected %0d",
                                              bit_value, want.bit_value));
                if (bit_index !== want.bit_index)
                    report_mismatch($sformatf("bit index %0d, expected %0d",
                                              bit_index, want.bit_index));
            end
        end
    end

    // Bound the run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("testbench NOT OK");
            $finish;
        end
    end

    initial
    begin
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int phase = 0; phase < 4; phase++)
        begin
            case (phase)
                0:       begin idle_pct = 0;  stall_pct = 0;  end
                1:       begin idle_pct = 87; stall_pct = 0;  end
                2:       begin idle_pct = 0;  stall_pct = 87; end
                default: begin idle_pct = 37; stall_pct = 37; end
            endcase
            if (phase == 0)
            begin
                foreach (edge_table[i])
                    send_edge(edge_table[i].level, edge_table[i].stamp,
                              edge_table[i].check, edge_table[i].want);
            end
            repeat (RANDOM_EDGES)
                random_edge();
            // Hold the sender until every expected bit has come out
            in_valid <= 1'b0;
            @(posedge clk);
            while (pending_bits.size() != 0)
                @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule

// ----- files.f -----
design/mted_pkg.sv
design/mted_in_reg.sv
design/mted_judge.sv
design/mted_out_reg.sv
design/manchester_edge_timing_decoder_top.sv
sim/testbench.sv
